/* src/ptc_pkg.sv */
// Shared types, widths and constants of the pressure and temperature compensation block.
// No dependencies; every other file of the block refers to this package by scoped names.
package ptc_pkg;

    // Fixed-point format and raw input widths.
    localparam int FRAC_W    = 32;
    localparam int RAW_W     = 24;
    localparam int SCALE_W   = 23;
    localparam int OUT_W     = 32;

    localparam logic [SCALE_W-1:0] SCALE_MIN = SCALE_W'(253952);
    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(524288);

    // Quotient of (|raw| << FRAC_W) / scale; the smallest scale keeps it below 2**QUOT_W.
    localparam int QUOT_W    = FRAC_W + 6;
    localparam int PRE_SHIFT = QUOT_W - FRAC_W;
    localparam int SC_W      = QUOT_W + 1;

    // Coefficient widths.
    localparam int C12_W = 12;
    localparam int C20_W = 20;
    localparam int C16_W = 16;

    // Intermediate widths of the polynomial.
    localparam int ACC1_W  = C16_W + SC_W + 1;
    localparam int TQ_W    = C12_W + SC_W + 1;
    localparam int C01T_W  = C16_W + SC_W;
    localparam int TEMP_SCALE = 1000;
    localparam int TPROD_W = TQ_W + 11;

    // Split multiplier lanes.
    localparam int LANE_A_W  = FRAC_W + 29;
    localparam int LANE_M_W  = LANE_A_W - 1;
    localparam int A_LO_W    = LANE_M_W / 2;
    localparam int A_HI_W    = LANE_M_W - A_LO_W;
    localparam int B_LO_W    = QUOT_W / 2;
    localparam int B_HI_W    = QUOT_W - B_LO_W;
    localparam int PP_W      = A_HI_W + B_HI_W;
    localparam int PL_W      = PP_W + A_LO_W + 1;
    localparam int PROD_W    = LANE_M_W + QUOT_W;
    localparam int MAGR_W    = PROD_W - FRAC_W;
    localparam int LANE_R_W  = MAGR_W + 1;
    localparam int MUL_LAT   = 5;
    localparam int NUM_LANES = 4;

    localparam int LANE_ACC1  = 0;
    localparam int LANE_INNER = 1;
    localparam int LANE_ACC2  = 2;
    localparam int LANE_CROSS = 3;

    localparam int SUM_W = LANE_R_W + 1;
    localparam int P_W   = LANE_R_W + 2;
    localparam int IP_W  = P_W - FRAC_W;

    // Register stages from input to output register.
    localparam int PIPE_LAT = QUOT_W + 2 * MUL_LAT + 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CALIB_LOW  = 3'd0,
        REG_CALIB_MID  = 3'd1,
        REG_CALIB_HIGH = 3'd2,
        REG_SCALE      = 3'd3
    } ptc_reg_t;

    typedef struct packed {
        logic signed [C12_W-1:0] c0;
        logic signed [C12_W-1:0] c1;
        logic signed [C20_W-1:0] c00;
        logic signed [C20_W-1:0] c10;
        logic signed [C16_W-1:0] c01;
        logic signed [C16_W-1:0] c11;
        logic signed [C16_W-1:0] c20;
        logic signed [C16_W-1:0] c21;
        logic signed [C16_W-1:0] c30;
    } ptc_coef_t;

endpackage

/* src/ptc_in_if.sv */
// Input channel of the compensation block: one raw temperature and pressure pair per item.
// Depends on ptc_pkg for the field widths.
interface ptc_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [ptc_pkg::RAW_W-1:0]   raw_temperature;
    logic signed [ptc_pkg::RAW_W-1:0]   raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

/* src/ptc_out_if.sv */
// Output channel of the compensation block: compensated pressure and temperature per item.
// Depends on ptc_pkg for the field widths.
interface ptc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ptc_pkg::OUT_W-1:0]   pressure_pascal;
    logic signed [ptc_pkg::OUT_W-1:0]   temperature_mcelsius;

    modport source (output valid, output pressure_pascal, output temperature_mcelsius,
                    input ready);
    modport sink   (input valid, input pressure_pascal, input temperature_mcelsius,
                    output ready);
endinterface

/* src/ptc_core.sv */
// Pipelined datapath of the compensation block: restoring dividers, split multiplier lanes,
// polynomial sums and output saturation. Depends on ptc_pkg.
module ptc_core (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [ptc_pkg::RAW_W-1:0]    raw_temperature,
    input  logic signed [ptc_pkg::RAW_W-1:0]    raw_pressure,
    input  ptc_pkg::ptc_coef_t                  coef,
    input  logic [ptc_pkg::SCALE_W-1:0]         divisor,
    output logic signed [ptc_pkg::OUT_W-1:0]    pressure_pascal,
    output logic signed [ptc_pkg::OUT_W-1:0]    temperature_mcelsius
);

    localparam int QW = ptc_pkg::QUOT_W;
    localparam int SW = ptc_pkg::SCALE_W;
    localparam int ML = ptc_pkg::MUL_LAT;
    localparam int DLY_N = 2 * ML + 1;
    localparam logic [ptc_pkg::IP_W-1:0] NEG_LIM =
        ptc_pkg::IP_W'(64'd1 << (ptc_pkg::OUT_W - 1));
    localparam logic [ptc_pkg::IP_W-1:0] POS_LIM =
        ptc_pkg::IP_W'((64'd1 << (ptc_pkg::OUT_W - 1)) - 64'd1);
    localparam logic signed [ptc_pkg::OUT_W-1:0] OUT_MIN = {1'b1, {(ptc_pkg::OUT_W-1){1'b0}}};
    localparam logic signed [ptc_pkg::OUT_W-1:0] OUT_MAX = {1'b0, {(ptc_pkg::OUT_W-1){1'b1}}};

    // Integer part of a magnitude, truncated toward zero and saturated to 32 bits.
    function automatic logic signed [ptc_pkg::OUT_W-1:0] sat_out(
        input logic                     neg,
        input logic [ptc_pkg::P_W-1:0]  mag
    );
        logic [ptc_pkg::IP_W-1:0] ip;
        ip = mag[ptc_pkg::P_W-1:ptc_pkg::FRAC_W];
        if (neg)
        begin
            if (ip > NEG_LIM)
                sat_out = OUT_MIN;
            else
                sat_out = -$signed(ip[ptc_pkg::OUT_W-1:0]);
        end
        else
        begin
            if (ip > POS_LIM)
                sat_out = OUT_MAX;
            else
                sat_out = $signed(ip[ptc_pkg::OUT_W-1:0]);
        end
    endfunction

    // ---------------- Divider: input stage and one quotient bit per stage ----------------
    logic [ptc_pkg::RAW_W-1:0] tmag_next, pmag_next;
    logic [SW-1:0]             trem_reg [QW+1];
    logic [SW-1:0]             prem_reg [QW+1];
    logic [QW-1:0]             tnq_reg  [QW+1];
    logic [QW-1:0]             pnq_reg  [QW+1];
    logic                      tsgn_reg [QW+1];
    logic                      psgn_reg [QW+1];

    always_comb
    begin
        tmag_next = raw_temperature[ptc_pkg::RAW_W-1] ? ptc_pkg::RAW_W'(-raw_temperature)
                                                      : ptc_pkg::RAW_W'(raw_temperature);
        pmag_next = raw_pressure[ptc_pkg::RAW_W-1] ? ptc_pkg::RAW_W'(-raw_pressure)
                                                   : ptc_pkg::RAW_W'(raw_pressure);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trem_reg[0] <= SW'(tmag_next[ptc_pkg::RAW_W-1:ptc_pkg::PRE_SHIFT]);
            prem_reg[0] <= SW'(pmag_next[ptc_pkg::RAW_W-1:ptc_pkg::PRE_SHIFT]);
            tnq_reg[0]  <= {tmag_next[ptc_pkg::PRE_SHIFT-1:0], {ptc_pkg::FRAC_W{1'b0}}};
            pnq_reg[0]  <= {pmag_next[ptc_pkg::PRE_SHIFT-1:0], {ptc_pkg::FRAC_W{1'b0}}};
            tsgn_reg[0] <= raw_temperature[ptc_pkg::RAW_W-1];
            psgn_reg[0] <= raw_pressure[ptc_pkg::RAW_W-1];
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        logic [SW:0] tt, pt, tdiff, pdiff;
        logic        tge, pge;

        always_comb
        begin
            tt    = {trem_reg[k-1], tnq_reg[k-1][QW-1]};
            pt    = {prem_reg[k-1], pnq_reg[k-1][QW-1]};
            tdiff = tt - {1'b0, divisor};
            pdiff = pt - {1'b0, divisor};
            tge   = tt >= {1'b0, divisor};
            pge   = pt >= {1'b0, divisor};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                trem_reg[k] <= tge ? tdiff[SW-1:0] : tt[SW-1:0];
                prem_reg[k] <= pge ? pdiff[SW-1:0] : pt[SW-1:0];
                tnq_reg[k]  <= {tnq_reg[k-1][QW-2:0], tge};
                pnq_reg[k]  <= {pnq_reg[k-1][QW-2:0], pge};
                tsgn_reg[k] <= tsgn_reg[k-1];
                psgn_reg[k] <= psgn_reg[k-1];
            end
        end
    end

    // ---------------- Signed scaled values ----------------
    logic signed [ptc_pkg::SC_W-1:0] sct_reg, scp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sct_reg <= tsgn_reg[QW] ? -$signed({1'b0, tnq_reg[QW]}) : $signed({1'b0, tnq_reg[QW]});
            scp_reg <= psgn_reg[QW] ? -$signed({1'b0, pnq_reg[QW]}) : $signed({1'b0, pnq_reg[QW]});
        end
    end

    // ---------------- First polynomial terms ----------------
    logic signed [ptc_pkg::ACC1_W-1:0]  acc1_next, inner_next, acc1_reg, inner_reg;
    logic signed [ptc_pkg::TQ_W-1:0]    tq_next, tq_reg;
    logic signed [ptc_pkg::C01T_W-1:0]  c01t_next, c01t_reg;
    logic signed [ptc_pkg::SC_W-1:0]    sa_reg, ta_reg;

    always_comb
    begin
        acc1_next  = (ptc_pkg::ACC1_W'(coef.c20) <<< ptc_pkg::FRAC_W)
                   + ptc_pkg::ACC1_W'(coef.c30) * ptc_pkg::ACC1_W'(scp_reg);
        inner_next = (ptc_pkg::ACC1_W'(coef.c11) <<< ptc_pkg::FRAC_W)
                   + ptc_pkg::ACC1_W'(coef.c21) * ptc_pkg::ACC1_W'(scp_reg);
        tq_next    = (ptc_pkg::TQ_W'(coef.c0) <<< (ptc_pkg::FRAC_W - 1))
                   + ptc_pkg::TQ_W'(coef.c1) * ptc_pkg::TQ_W'(sct_reg);
        c01t_next  = ptc_pkg::C01T_W'(coef.c01) * ptc_pkg::C01T_W'(sct_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc1_reg  <= acc1_next;
            inner_reg <= inner_next;
            tq_reg    <= tq_next;
            c01t_reg  <= c01t_next;
            sa_reg    <= scp_reg;
            ta_reg    <= sct_reg;
        end
    end

    // ---------------- Delay lines that run beside the multiplier lanes ----------------
    logic signed [ptc_pkg::C01T_W-1:0]  c01t_dly_reg  [DLY_N];
    logic signed [ptc_pkg::TPROD_W-1:0] tprod_dly_reg [DLY_N];
    logic signed [ptc_pkg::SC_W-1:0]    s_dly_reg     [ML];
    logic signed [ptc_pkg::SC_W-1:0]    t_dly_reg     [ML];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c01t_dly_reg[0]  <= c01t_reg;
            tprod_dly_reg[0] <= ptc_pkg::TPROD_W'(tq_reg)
                              * ptc_pkg::TPROD_W'(ptc_pkg::TEMP_SCALE);
            for (int j = 1; j < DLY_N; j++)
            begin
                c01t_dly_reg[j]  <= c01t_dly_reg[j-1];
                tprod_dly_reg[j] <= tprod_dly_reg[j-1];
            end
            s_dly_reg[0] <= sa_reg;
            t_dly_reg[0] <= ta_reg;
            for (int j = 1; j < ML; j++)
            begin
                s_dly_reg[j] <= s_dly_reg[j-1];
                t_dly_reg[j] <= t_dly_reg[j-1];
            end
        end
    end

    // ---------------- Multiplier lanes: sign-magnitude product truncated by FRAC_W ----------------
    logic signed [ptc_pkg::LANE_A_W-1:0] lane_a [ptc_pkg::NUM_LANES];
    logic signed [ptc_pkg::SC_W-1:0]     lane_b [ptc_pkg::NUM_LANES];
    logic signed [ptc_pkg::LANE_R_W-1:0] lane_r [ptc_pkg::NUM_LANES];

    logic signed [ptc_pkg::LANE_A_W-1:0] acc2_next, acc2_reg, m5c_reg;
    logic signed [ptc_pkg::SC_W-1:0]     sc_reg, tc_reg;

    assign lane_a[ptc_pkg::LANE_ACC1]  = ptc_pkg::LANE_A_W'(acc1_reg);
    assign lane_b[ptc_pkg::LANE_ACC1]  = sa_reg;
    assign lane_a[ptc_pkg::LANE_INNER] = ptc_pkg::LANE_A_W'(inner_reg);
    assign lane_b[ptc_pkg::LANE_INNER] = sa_reg;
    assign lane_a[ptc_pkg::LANE_ACC2]  = acc2_reg;
    assign lane_b[ptc_pkg::LANE_ACC2]  = sc_reg;
    assign lane_a[ptc_pkg::LANE_CROSS] = m5c_reg;
    assign lane_b[ptc_pkg::LANE_CROSS] = tc_reg;

    for (genvar n = 0; n < ptc_pkg::NUM_LANES; n++)
    begin : g_lane
        logic [ML-2:0]                  neg_reg;
        logic [ptc_pkg::LANE_M_W-1:0]   ma_reg;
        logic [QW-1:0]                  mb_reg;
        logic [ptc_pkg::PP_W-1:0]       pp00_reg, pp01_reg, pp10_reg, pp11_reg;
        logic [ptc_pkg::PL_W-1:0]       plo_reg, phi_reg;
        logic [ptc_pkg::PROD_W-1:0]     full_next;
        logic [ptc_pkg::MAGR_W-1:0]     mag_reg;
        logic signed [ptc_pkg::LANE_R_W-1:0] res_reg;

        assign full_next = ptc_pkg::PROD_W'(plo_reg)
                         + (ptc_pkg::PROD_W'(phi_reg) << ptc_pkg::B_LO_W);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg <= {neg_reg[ML-3:0],
                            lane_a[n][ptc_pkg::LANE_A_W-1] ^ lane_b[n][ptc_pkg::SC_W-1]};
                ma_reg  <= lane_a[n][ptc_pkg::LANE_A_W-1] ? ptc_pkg::LANE_M_W'(-lane_a[n])
                                                          : ptc_pkg::LANE_M_W'(lane_a[n]);
                mb_reg  <= lane_b[n][ptc_pkg::SC_W-1] ? QW'(-lane_b[n]) : QW'(lane_b[n]);

                pp00_reg <= ptc_pkg::PP_W'(ma_reg[ptc_pkg::A_LO_W-1:0])
                          * ptc_pkg::PP_W'(mb_reg[ptc_pkg::B_LO_W-1:0]);
                pp01_reg <= ptc_pkg::PP_W'(ma_reg[ptc_pkg::A_LO_W-1:0])
                          * ptc_pkg::PP_W'(mb_reg[QW-1:ptc_pkg::B_LO_W]);
                pp10_reg <= ptc_pkg::PP_W'(ma_reg[ptc_pkg::LANE_M_W-1:ptc_pkg::A_LO_W])
                          * ptc_pkg::PP_W'(mb_reg[ptc_pkg::B_LO_W-1:0]);
                pp11_reg <= ptc_pkg::PP_W'(ma_reg[ptc_pkg::LANE_M_W-1:ptc_pkg::A_LO_W])
                          * ptc_pkg::PP_W'(mb_reg[QW-1:ptc_pkg::B_LO_W]);

                plo_reg <= ptc_pkg::PL_W'(pp00_reg) + (ptc_pkg::PL_W'(pp10_reg) << ptc_pkg::A_LO_W);
                phi_reg <= ptc_pkg::PL_W'(pp01_reg) + (ptc_pkg::PL_W'(pp11_reg) << ptc_pkg::A_LO_W);

                mag_reg <= full_next[ptc_pkg::PROD_W-1:ptc_pkg::FRAC_W];

                res_reg <= neg_reg[ML-2] ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
            end
        end

        assign lane_r[n] = res_reg;
    end

    // ---------------- Second polynomial stage ----------------
    assign acc2_next = ptc_pkg::LANE_A_W'((ptc_pkg::LANE_R_W'(coef.c10) <<< ptc_pkg::FRAC_W)
                                          + lane_r[ptc_pkg::LANE_ACC1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            acc2_reg <= acc2_next;
            m5c_reg  <= ptc_pkg::LANE_A_W'(lane_r[ptc_pkg::LANE_INNER]);
            sc_reg   <= s_dly_reg[ML-1];
            tc_reg   <= t_dly_reg[ML-1];
        end
    end

    // ---------------- Final sums and output ----------------
    logic signed [ptc_pkg::SUM_W-1:0]   sum1_reg, sum2_reg;
    logic signed [ptc_pkg::P_W-1:0]     p_reg;
    logic signed [ptc_pkg::TPROD_W-1:0] tm1_reg, tm2_reg;
    logic                               pneg_reg, tneg_reg;
    logic [ptc_pkg::P_W-1:0]            pmag_reg, tmag_reg;
    logic signed [ptc_pkg::OUT_W-1:0]   pout_reg, tout_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum1_reg <= ptc_pkg::SUM_W'(lane_r[ptc_pkg::LANE_ACC2])
                      + ptc_pkg::SUM_W'(lane_r[ptc_pkg::LANE_CROSS]);
            sum2_reg <= (ptc_pkg::SUM_W'(coef.c00) <<< ptc_pkg::FRAC_W)
                      + ptc_pkg::SUM_W'(c01t_dly_reg[DLY_N-1]);
            tm1_reg  <= tprod_dly_reg[DLY_N-1];

            p_reg    <= ptc_pkg::P_W'(sum1_reg) + ptc_pkg::P_W'(sum2_reg);
            tm2_reg  <= tm1_reg;

            pneg_reg <= p_reg[ptc_pkg::P_W-1];
            pmag_reg <= p_reg[ptc_pkg::P_W-1] ? ptc_pkg::P_W'(-p_reg) : ptc_pkg::P_W'(p_reg);
            tneg_reg <= tm2_reg[ptc_pkg::TPROD_W-1];
            tmag_reg <= tm2_reg[ptc_pkg::TPROD_W-1]
                      ? ptc_pkg::P_W'(ptc_pkg::TPROD_W'(-tm2_reg))
                      : ptc_pkg::P_W'(ptc_pkg::TPROD_W'(tm2_reg));

            pout_reg <= sat_out(pneg_reg, pmag_reg);
            tout_reg <= sat_out(tneg_reg, tmag_reg);
        end
    end

    assign pressure_pascal      = pout_reg;
    assign temperature_mcelsius = tout_reg;

endmodule

/* src/pressure_temperature_compensation_top.sv */
// Top level of the barometric pressure and temperature compensation block.
// Depends on ptc_pkg, ptc_in_if, ptc_out_if and ptc_core.
//
// Usage: raw readings arrive as items on the sample channel (valid/ready), one signed
// 24-bit temperature and one signed 24-bit pressure each. Every item yields exactly one
// item on the result channel: pressure in pascal and temperature in millidegrees Celsius,
// both truncated toward zero and saturated to 32-bit signed.
// Calibration bytes and the raw scale factor are to be loaded through the write port
// (cfg_we, cfg_index, cfg_wdata) while no item is in flight; the block does not check it.
//
// The pipeline has PIPE_LAT = QUOT_W + 2*MUL_LAT + 8 = 56 register stages. An item
// accepted by the input stage passes through every stage in order and is shown on the
// result channel from the last one. One item is accepted every cycle while the pipeline
// is not stalled. The depth is set by the restoring dividers, which produce one quotient
// bit per stage, and by the two chained split multiplier lanes of five stages each in
// the pressure polynomial.
//
// Reset clears the valid bits of the pipeline and loads the register reset values (zero
// calibration, scale factor 524288). When the receiver holds ready low while a result
// waits, the whole pipeline freezes with its data in place, and sample.ready stays low
// until the result is taken; nothing is lost or repeated.
module pressure_temperature_compensation_top (
    input  logic                                clk,
    input  logic                                rst_n,
    ptc_in_if.sink                              sample,
    ptc_out_if.source                           result,
    input  logic                                cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // Configuration registers.
    logic [63:0]                  calib_low_reg;
    logic [63:0]                  calib_mid_reg;
    logic [15:0]                  calib_high_reg;
    logic [ptc_pkg::SCALE_W-1:0]  scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_low_reg  <= '0;
            calib_mid_reg  <= '0;
            calib_high_reg <= '0;
            scale_reg      <= ptc_pkg::SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ptc_pkg::REG_CALIB_LOW:  calib_low_reg  <= cfg_wdata;
                ptc_pkg::REG_CALIB_MID:  calib_mid_reg  <= cfg_wdata;
                ptc_pkg::REG_CALIB_HIGH: calib_high_reg <= cfg_wdata[15:0];
                ptc_pkg::REG_SCALE:      scale_reg      <= cfg_wdata[ptc_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // The coefficients sit at fixed bit positions of the calibration bytes.
    ptc_pkg::ptc_coef_t coef;

    always_comb
    begin
        coef.c0  = $signed(calib_low_reg[63:52]);
        coef.c1  = $signed(calib_low_reg[51:40]);
        coef.c00 = $signed(calib_low_reg[39:20]);
        coef.c10 = $signed(calib_low_reg[19:0]);
        coef.c01 = $signed(calib_mid_reg[63:48]);
        coef.c11 = $signed(calib_mid_reg[47:32]);
        coef.c20 = $signed(calib_mid_reg[31:16]);
        coef.c21 = $signed(calib_mid_reg[15:0]);
        coef.c30 = $signed(calib_high_reg);
    end

    // A scale factor below the supported minimum, zero included, is raised to the minimum.
    logic [ptc_pkg::SCALE_W-1:0] div_eff;
    assign div_eff = (scale_reg < ptc_pkg::SCALE_MIN) ? ptc_pkg::SCALE_MIN : scale_reg;

    // Valid bits travel beside the data; the pipeline advances as a whole whenever the
    // output register is empty or being drained.
    logic [ptc_pkg::PIPE_LAT-1:0] vld_reg;
    logic                         en;

    assign en = !vld_reg[ptc_pkg::PIPE_LAT-1] || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[ptc_pkg::PIPE_LAT-2:0], sample.valid};
    end

    assign sample.ready = en;
    assign result.valid = vld_reg[ptc_pkg::PIPE_LAT-1];

    ptc_core u_core (
        .clk                  (clk),
        .en                   (en),
        .raw_temperature      (sample.raw_temperature),
        .raw_pressure         (sample.raw_pressure),
        .coef                 (coef),
        .divisor              (div_eff),
        .pressure_pascal      (result.pressure_pascal),
        .temperature_mcelsius (result.temperature_mcelsius)
    );

    // An accepted item always occupies the first stage in the next cycle.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> vld_reg[0])
        else $error("accepted item did not enter the pipeline");

    // An item moves one stage forward whenever the pipeline advances.
    a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && en |=> vld_reg[1])
        else $error("item lost between the first two stages");

    // A stall freezes every valid bit.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved during a stall");

    // The divisor never falls below the supported minimum.
    a_divisor_floor: assert property (@(posedge clk) disable iff (!rst_n)
        div_eff >= ptc_pkg::SCALE_MIN)
        else $error("divisor below minimum");

endmodule
